// ===== hw/rtl/ssc_pkg.sv =====
// Shared constants and types for the sensor sample conditioner.
`default_nettype none

package ssc_pkg;

    // Default depth of the moving-average window.
    localparam int DEF_WINDOW_DEPTH = 8;

    // Field and port widths.
    localparam int RAW_W       = 12;
    localparam int VAL_W       = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 5 * VAL_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAL_VALID     = 2'd0,
        CFG_CAL_OFFSET    = 2'd1,
        CFG_CAL_SCALE     = 2'd2,
        CFG_FILTER_ENABLE = 2'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [VAL_W-1:0] CAL_SCALE_RESET = 32'h0001_0000;

    // Conversion constants: value = round((mV - 500) * 6553.6).
    localparam logic [RAW_W-1:0] MV_OFFSET  = 12'd500;
    localparam logic [24:0]      CONV_INT   = 25'd6553;
    // 52429 / 2^19 stands in for one tenth over the whole input range.
    localparam logic [30:0]      CONV_RECIP = 31'd52429;
    localparam int               CONV_SHIFT = 19;

endpackage : ssc_pkg

`default_nettype wire

// ===== hw/rtl/sensor_sample_conditioner_top.sv =====
// Sensor sample conditioner: conversion, calibration, window mean and statistics.
//
//  Channel   Direction  Signals                       Contents
//  s_*       in         s_tvalid/s_tready/s_tdata     raw sample word
//  m_*       out        m_tvalid/m_tready/m_tdata     conditioned result word
//  cfg_*     in         cfg_we/cfg_index/cfg_data     register writes
//
// A word passes through conversion and statistics. Calibration adds a pass
// through the shared 33x16 multiplier, low half of the scale, then high half;
// filtering adds the window read and update and the serial divider, one
// quotient bit per cycle (SUM_W = 33 + clog2(depth) bits). The input is ready only in
// the idle state; a result held by the sink stalls the next word before its
// statistics update. Reset clears the statistics and the window counters.
`default_nettype none

module sensor_sample_conditioner_top #(
    parameter int WINDOW_DEPTH = ssc_pkg::DEF_WINDOW_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] raw_millivolts, [15:12] zero
    input  wire logic [ssc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] filtered_value, [63:32] min_value, [95:64] max_value,
    // [127:96] smoothed_average, [159:128] reading_total
    output logic [ssc_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssc_pkg::*;

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = 33 + $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(SUM_W + 1);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_CONV     = 12'b0000_0000_0010,
        ST_CAL_PREP = 12'b0000_0000_0100,
        ST_MUL_LO   = 12'b0000_0000_1000,
        ST_MUL_HI   = 12'b0000_0001_0000,
        ST_CAL_FIN  = 12'b0000_0010_0000,
        ST_WIN_RD   = 12'b0000_0100_0000,
        ST_WIN_UPD  = 12'b0000_1000_0000,
        ST_DIV_PREP = 12'b0001_0000_0000,
        ST_DIV      = 12'b0010_0000_0000,
        ST_DIV_FIN  = 12'b0100_0000_0000,
        ST_STATS    = 12'b1000_0000_0000
    } state_t;

    // Control registers.
    state_t                  state_reg, state_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    cal_valid_reg;
    logic                    filter_enable_reg;
    logic [VAL_W-1:0]        cal_offset_reg;
    logic [VAL_W-1:0]        cal_scale_reg;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [VAL_W-1:0]        total_reg, total_next;
    logic [VAL_W-1:0]        min_reg, min_next;
    logic [VAL_W-1:0]        max_reg, max_next;
    logic [VAL_W-1:0]        ema_reg, ema_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // Datapath registers.
    logic [RAW_W-1:0]        mv_reg, mv_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [VAL_W-1:0]        filt_reg, filt_next;
    logic [32:0]             diff_mag_reg, diff_mag_next;
    logic [VAL_W-1:0]        scale_mag_reg, scale_mag_next;
    logic                    cal_neg_reg, cal_neg_next;
    logic [63:0]             acc_reg, acc_next;
    logic [SUM_W-1:0]        dvd_reg, dvd_next;
    logic [FILL_W-1:0]       rem_reg, rem_next;
    logic                    div_neg_reg, div_neg_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Window memory.
    logic [VAL_W-1:0]        mem [WINDOW_DEPTH];
    logic [VAL_W-1:0]        mem_q;
    logic                    mem_we;

    // Conversion from millivolts to Q16.16 degrees.
    logic                    conv_neg;
    logic [RAW_W-1:0]        conv_mag;
    logic [14:0]             conv_x;
    logic [30:0]             conv_frac;
    logic [24:0]             conv_int;
    logic [24:0]             conv_q;
    logic [VAL_W-1:0]        conv_val;

    assign conv_neg  = mv_reg < MV_OFFSET;
    assign conv_mag  = conv_neg ? (MV_OFFSET - mv_reg) : (mv_reg - MV_OFFSET);
    assign conv_x    = 15'(conv_mag) * 15'd6 + 15'd5;
    assign conv_frac = 31'(conv_x) * CONV_RECIP;
    assign conv_int  = 25'(conv_mag) * CONV_INT;
    assign conv_q    = conv_int + 25'(conv_frac[30:CONV_SHIFT]);
    assign conv_val  = conv_neg ? (32'd0 - 32'(conv_q)) : 32'(conv_q);

    // Calibration operands in sign and magnitude form.
    logic [32:0]             diff;
    logic [48:0]             mul_p;
    logic [15:0]             mul_b;
    logic [47:0]             cal_r;
    logic [VAL_W-1:0]        cal_sat;

    assign diff  = {val_reg[31], val_reg} - {cal_offset_reg[31], cal_offset_reg};
    // Shared multiplier: low half of the scale first, then the high half.
    assign mul_b = (state_reg == ST_MUL_HI) ? scale_mag_reg[31:16] : scale_mag_reg[15:0];
    assign mul_p = 49'(diff_mag_reg) * 49'(mul_b);
    assign cal_r = 48'((acc_reg + 64'd32768) >> 16);

    always_comb
    begin
        if (cal_neg_reg)
        begin
            cal_sat = (cal_r > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - cal_r[31:0]);
        end
        else
        begin
            cal_sat = (cal_r > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : cal_r[31:0];
        end
    end

    // Window update and serial divider step.
    logic                    win_full;
    logic [SUM_W-1:0]        win_old;
    logic [SUM_W-1:0]        sum_mag;
    logic [FILL_W:0]         rem_sh;
    logic [FILL_W:0]         rem_sub;
    logic                    rem_ge;
    logic [VAL_W-1:0]        quo;

    assign win_full = fill_reg == FILL_W'(WINDOW_DEPTH);
    assign win_old  = win_full ? {{(SUM_W-VAL_W){mem_q[31]}}, mem_q} : '0;
    assign sum_mag  = sum_reg[SUM_W-1] ? ('0 - sum_reg) : sum_reg;
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, fill_reg};
    assign rem_sub  = rem_sh - {1'b0, fill_reg};
    assign quo      = dvd_reg[VAL_W-1:0];

    // Statistics: min, max and the exponential average.
    logic                    first_read;
    logic [35:0]             ema_m;
    logic [35:0]             ema_n;
    logic [35:0]             ema_mag;
    logic [35:0]             ema_r;
    logic [VAL_W-1:0]        ema_val;
    logic [VAL_W-1:0]        min_upd;
    logic [VAL_W-1:0]        max_upd;

    assign first_read = total_reg == '0;
    assign ema_m      = {{4{ema_reg[31]}}, ema_reg};
    assign ema_n      = (ema_m << 3) - ema_m + {{4{filt_reg[31]}}, filt_reg};
    assign ema_mag    = ema_n[35] ? (36'd0 - ema_n) : ema_n;
    assign ema_r      = (ema_mag + 36'd4) >> 3;
    assign ema_val    = ema_n[35] ? (32'd0 - ema_r[31:0]) : ema_r[31:0];
    assign min_upd    = ($signed(filt_reg) < $signed(min_reg)) ? filt_reg : min_reg;
    assign max_upd    = ($signed(filt_reg) > $signed(max_reg)) ? filt_reg : max_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        ema_next       = ema_reg;
        cnt_next       = cnt_reg;
        mv_next        = mv_reg;
        val_next       = val_reg;
        filt_next      = filt_reg;
        diff_mag_next  = diff_mag_reg;
        scale_mag_next = scale_mag_reg;
        cal_neg_next   = cal_neg_reg;
        acc_next       = acc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_neg_next   = div_neg_reg;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mv_next    = s_tdata[RAW_W-1:0];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                val_next  = conv_val;
                filt_next = conv_val;
                if (cal_valid_reg)
                begin
                    state_next = ST_CAL_PREP;
                end
                else if (filter_enable_reg)
                begin
                    state_next = ST_WIN_RD;
                end
                else
                begin
                    state_next = ST_STATS;
                end
            end
            ST_CAL_PREP:
            begin
                diff_mag_next  = diff[32] ? (33'd0 - diff) : diff;
                scale_mag_next = cal_scale_reg[31] ? (32'd0 - cal_scale_reg) : cal_scale_reg;
                cal_neg_next   = diff[32] ^ cal_scale_reg[31];
                state_next     = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                acc_next   = 64'(mul_p);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                acc_next   = acc_reg + (64'(mul_p) << 16);
                state_next = ST_CAL_FIN;
            end
            ST_CAL_FIN:
            begin
                val_next   = cal_sat;
                filt_next  = cal_sat;
                state_next = filter_enable_reg ? ST_WIN_RD : ST_STATS;
            end
            ST_WIN_RD:
            begin
                // The memory read of the slot lands in mem_q this cycle.
                state_next = ST_WIN_UPD;
            end
            ST_WIN_UPD:
            begin
                mem_we    = 1'b1;
                sum_next  = sum_reg - win_old + {{(SUM_W-VAL_W){val_reg[31]}}, val_reg};
                slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (!win_full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_DIV_PREP;
            end
            ST_DIV_PREP:
            begin
                // Round to nearest by adding half the divisor to the magnitude.
                div_neg_next = sum_reg[SUM_W-1];
                dvd_next     = sum_mag + SUM_W'(fill_reg >> 1);
                rem_next     = '0;
                cnt_next     = CNT_W'(SUM_W);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN:
            begin
                filt_next  = div_neg_reg ? (32'd0 - quo) : quo;
                state_next = ST_STATS;
            end
            ST_STATS:
            begin
                // Wait until the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    if (first_read)
                    begin
                        min_next = filt_reg;
                        max_next = filt_reg;
                        ema_next = filt_reg;
                    end
                    else
                    begin
                        min_next = min_upd;
                        max_next = max_upd;
                        ema_next = ema_val;
                    end
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    m_tdata_next  = {total_next, ema_next, max_next, min_next, filt_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            total_reg    <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            ema_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            total_reg    <= total_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            ema_reg      <= ema_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mv_reg        <= mv_next;
        val_reg       <= val_next;
        filt_reg      <= filt_next;
        diff_mag_reg  <= diff_mag_next;
        scale_mag_reg <= scale_mag_next;
        cal_neg_reg   <= cal_neg_next;
        acc_reg       <= acc_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        div_neg_reg   <= div_neg_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Window memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= val_reg;
        end
        mem_q <= mem[slot_reg];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_valid_reg     <= 1'b0;
            cal_offset_reg    <= '0;
            cal_scale_reg     <= CAL_SCALE_RESET;
            filter_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CAL_VALID:     cal_valid_reg     <= cfg_data[0];
                CFG_CAL_OFFSET:    cal_offset_reg    <= cfg_data[VAL_W-1:0];
                CFG_CAL_SCALE:     cal_scale_reg     <= cfg_data[VAL_W-1:0];
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                default:           cal_valid_reg     <= cal_valid_reg;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : sensor_sample_conditioner_top

`default_nettype wire

// ===== tb/sv/sensor_sample_conditioner_top_test.sv =====
// Self-checking testbench for the sensor sample conditioner top level.
`timescale 1ns / 1ps

module sensor_sample_conditioner_top_test;

    import ssc_pkg::*;

    localparam int WIN_DEPTH      = DEF_WINDOW_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [VAL_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [VAL_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam longint           INT_TOP       = 64'sd2147483647;
    localparam longint           INT_BOTTOM    = -64'sd2147483648;

    // One result word, laid out as on m_tdata (last field in the lowest bits).
    typedef struct packed {
        logic [VAL_W-1:0] reading_total;
        logic [VAL_W-1:0] smoothed_average;
        logic [VAL_W-1:0] max_value;
        logic [VAL_W-1:0] min_value;
        logic [VAL_W-1:0] filtered_value;
    } reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the registers.
    bit          cal_on    = 1'b0;
    int          cal_shift = 0;
    int          cal_gain  = 65536;
    bit          window_on = 1'b1;

    // Shadow copy of the window and the statistics.
    int          window_vals [WIN_DEPTH];
    int unsigned slot_ptr      = 0;
    int unsigned fill_cnt      = 0;
    longint      window_total  = 0;
    int unsigned readings_seen = 0;
    int          lowest_q      = 0;
    int          highest_q     = 0;
    int          average_q     = 0;

    reading_t    pending_readings [$];
    int          fail_count = 0;
    bit          idle_on    = 1'b1;

    sensor_sample_conditioner_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Division rounded to nearest, ties away from zero; den is positive.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic int clamp32(longint v);
        if (v > INT_TOP)
            return int'(INT_TOP);
        if (v < INT_BOTTOM)
            return int'(INT_BOTTOM);
        return int'(v);
    endfunction

    // Works out the result word for one sample and advances the shadow state.
    function automatic reading_t condition_reading(logic [RAW_W-1:0] mv);
        longint   level;
        int       out_level;
        reading_t res;
        level = round_div((longint'(mv) - 500) * 65536, 10);
        if (cal_on)
            level = clamp32(round_div((level - longint'(cal_shift)) * longint'(cal_gain),
                                      65536));
        if (window_on)
        begin
            // Once the window is full the oldest entry drops out of the sum.
            if (fill_cnt >= WIN_DEPTH)
                window_total -= window_vals[slot_ptr];
            window_vals[slot_ptr] = int'(level);
            window_total += level;
            slot_ptr = (slot_ptr + 1) % WIN_DEPTH;
            if (fill_cnt < WIN_DEPTH)
                fill_cnt++;
            out_level = clamp32(round_div(window_total, fill_cnt));
        end
        else
            out_level = int'(level);
        // The first reading seeds the minimum, the maximum and the average.
        if (readings_seen == 0)
        begin
            lowest_q  = out_level;
            highest_q = out_level;
            average_q = out_level;
        end
        else
        begin
            if (out_level < lowest_q)
                lowest_q = out_level;
            if (out_level > highest_q)
                highest_q = out_level;
            average_q = clamp32(round_div(longint'(average_q) * 7 + out_level, 8));
        end
        if (readings_seen != 32'hFFFF_FFFF)
            readings_seen++;
        res.filtered_value   = out_level;
        res.min_value        = lowest_q;
        res.max_value        = highest_q;
        res.smoothed_average = average_q;
        res.reading_total    = readings_seen;
        return res;
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0d at %0t: %s", fail_count, $time, msg);
    endfunction

    function automatic void compare_field(string label, logic [VAL_W-1:0] want,
                                          logic [VAL_W-1:0] got);
        if (got !== want)
            report_failure($sformatf("%s expected %h (%0d), got %h (%0d)", label,
                                     want, $signed(want), got, $signed(got)));
    endfunction

    // Sends one sample word, with a random gap before it while idling is on.
    task automatic send_sample(logic [RAW_W-1:0] mv);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= S_TDATA_W'(mv);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_readings.push_back(condition_reading(mv));
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] word);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        case (idx)
            CFG_CAL_VALID:     cal_on    = word[0];
            CFG_CAL_OFFSET:    cal_shift = word;
            CFG_CAL_SCALE:     cal_gain  = word;
            CFG_FILTER_ENABLE: window_on = word[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Register writes happen only once the block has gone idle.
    task automatic apply_settings(logic [CFG_DATA_W-1:0] cal_word,
                                  logic [CFG_DATA_W-1:0] offset_word,
                                  logic [CFG_DATA_W-1:0] gain_word,
                                  logic [CFG_DATA_W-1:0] filter_word);
        wait_drained();
        set_reg(CFG_CAL_VALID, cal_word);
        set_reg(CFG_CAL_OFFSET, offset_word);
        set_reg(CFG_CAL_SCALE, gain_word);
        set_reg(CFG_FILTER_ENABLE, filter_word);
    endtask

    // Reset settings: conversion extremes, the zero point, seeding and window wrap.
    task automatic test_power_on_defaults();
        logic [RAW_W-1:0] samples [10] = '{0, 4095, 500, 499, 501, 4094, 1, 2048, 3000, 100};
        foreach (samples[i])
            send_sample(samples[i]);
    endtask

    // With the filter off the converted value passes straight through.
    task automatic test_filter_bypass();
        apply_settings(0, 0, CAL_SCALE_RESET, 0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd500);
        send_sample(12'd1234);
    endtask

    // Calibration at the register extremes, saturating both ways.
    task automatic test_calibration_limits();
        apply_settings(1, MOST_NEGATIVE, MOST_POSITIVE, 0);
        send_sample(12'd4095);
        apply_settings(1, MOST_POSITIVE, MOST_POSITIVE, 0);
        send_sample(12'd0);
        apply_settings(1, 0, MOST_NEGATIVE, 0);
        send_sample(12'd4095);
        send_sample(12'd0);
        apply_settings(1, 0, 0, 0);
        send_sample(12'd2500);
        apply_settings(1, 32'h0019_0000, 32'h0001_8000, 1);
        send_sample(12'd750);
        send_sample(12'd1750);
        send_sample(12'd3333);
    endtask

    // One phase: random settings, then random samples with the odd full drain.
    task automatic run_random_phase(int count);
        logic [CFG_DATA_W-1:0] offset_word;
        logic [CFG_DATA_W-1:0] gain_word;
        logic [RAW_W-1:0]      mv;
        case ($urandom_range(0, 5))
            0:       offset_word = MOST_NEGATIVE;
            1:       offset_word = MOST_POSITIVE;
            2:       offset_word = $urandom();
            default: offset_word = $urandom_range(0, 80 << 16) - (40 << 16);
        endcase
        case ($urandom_range(0, 6))
            0:       gain_word = MOST_NEGATIVE;
            1:       gain_word = MOST_POSITIVE;
            2:       gain_word = $urandom();
            3:       gain_word = '0;
            default: gain_word = $urandom_range(0, 4 << 16) - (2 << 16);
        endcase
        // Upper bits of the one-bit registers are random too.
        apply_settings($urandom(), offset_word, gain_word, $urandom());
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 || $urandom_range(0, 39) == 0)
                wait_drained();
            case ($urandom_range(0, 9))
                0:       mv = '0;
                1:       mv = '1;
                2:       mv = RAW_W'(490 + $urandom_range(0, 20));
                default: mv = RAW_W'($urandom_range(0, 4095));
            endcase
            send_sample(mv);
        end
    endtask

    task automatic test_random_settings();
        repeat (8) run_random_phase(100);
    endtask

    // Last stretch with both sides always ready.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_random_phase(100);
    endtask

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side ready, with random stall bursts while idling is on.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Each accepted result word is checked against the oldest expectation.
    initial
    begin : result_check
        reading_t got;
        reading_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_readings.size() == 0)
                    report_failure($sformatf("result word %h with nothing expected", got));
                else
                begin
                    want = pending_readings.pop_front();
                    compare_field("filtered_value", want.filtered_value, got.filtered_value);
                    compare_field("min_value", want.min_value, got.min_value);
                    compare_field("max_value", want.max_value, got.max_value);
                    compare_field("smoothed_average", want.smoothed_average,
                                  got.smoothed_average);
                    compare_field("reading_total", want.reading_total, got.reading_total);
                end
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CAL_VALID;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_filter_bypass();
        test_calibration_limits();
        test_random_settings();
        test_steady_stream();

        // Drain, then give a stray extra word time to show up.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            report_failure("expected results still outstanding");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ssc_pkg.sv
hw/rtl/sensor_sample_conditioner_top.sv
tb/sv/sensor_sample_conditioner_top_test.sv
